>>> rtl/core/bcm_pkg.sv
`timescale 1ns / 1ps
// bcm_pkg: shared types and constants of the banded rainbow colour map
// used by bcm_lvl_div and banded_rainbow_colormap; no dependencies
package bcm_pkg;

	localparam int MAX_COLORS = 4096;
	localparam int IDX_W      = $clog2(MAX_COLORS);
	localparam int CNT_W      = 13;
	localparam int WIDTH_W    = 31;
	localparam int LEVEL_W    = 32;

	typedef enum logic [2:0] {
		REG_MIN_LEVEL        = 3'd0,
		REG_MAX_LEVEL        = 3'd1,
		REG_SEGMENT_WIDTH    = 3'd2,
		REG_COLOR_COUNT      = 3'd3,
		REG_STRIPE_DIVISIONS = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		SPC_NONE,
		SPC_NAN,
		SPC_INF
	} special_t;

	typedef enum logic [1:0] {
		SEL_DIV,
		SEL_TOP,
		SEL_ZERO
	} idx_sel_t;

	typedef enum logic [1:0] {
		LVL_DIV,
		LVL_ZERO,
		LVL_NEG
	} lvl_mode_t;

	// segment count of the mapped range, as the index divider needs it
	typedef struct packed {
		lvl_mode_t           mode;
		logic [LEVEL_W-1:0]  segs;
	} lvl_info_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} rgba_t;

	localparam logic signed [LEVEL_W-1:0] RST_MIN_LEVEL        = 32'sd0;
	localparam logic signed [LEVEL_W-1:0] RST_MAX_LEVEL        = 32'sd65536;
	localparam logic [WIDTH_W-1:0]        RST_SEGMENT_WIDTH    = 31'd65536;
	localparam logic [CNT_W-1:0]          RST_COLOR_COUNT      = 13'd16;
	localparam logic [7:0]                RST_STRIPE_DIVISIONS = 8'd0;
	localparam logic [LEVEL_W-1:0]        RST_LVL_SEGS         = 32'd1;

	// 2 * 255 * 4 and 2 * 255 * 3: full and darkened channel gain
	localparam logic [10:0] CHAN_GAIN_FULL = 11'd2040;
	localparam logic [10:0] CHAN_GAIN_DARK = 11'd1530;

endpackage

>>> rtl/core/bcm_div_pipe.sv
`timescale 1ns / 1ps
// bcm_div_pipe: pipelined restoring divider, one quotient bit per stage
// divisor is held steady by the caller; needs dividend < divisor << QW
module bcm_div_pipe #(
	parameter int NW   = 33,
	parameter int QW   = 32,
	parameter int DIVW = 31,
	parameter int SW   = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [NW-1:0]   dividend,
	input  logic [DIVW-1:0] divisor,
	input  logic [SW-1:0]   in_side,
	output logic            out_valid,
	output logic [QW-1:0]   quotient,
	output logic [DIVW-1:0] remainder,
	output logic [SW-1:0]   out_side
);

	localparam int TW = NW - QW;

	logic [DIVW-1:0] rem_init;
	logic [DIVW-1:0] rem_s  [QW];
	logic [QW-1:0]   quo_s  [QW];
	logic [SW-1:0]   side_s [QW];
	logic            vld_s  [QW];

	// upper dividend bits seed the partial remainder
	if (TW >= DIVW) begin : g_trunc
		assign rem_init = dividend[QW +: DIVW];
	end else begin : g_ext
		assign rem_init = {{(DIVW-TW){1'b0}}, dividend[NW-1:QW]};
	end

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DIVW-1:0] rem_in;
		logic [QW-1:0]   quo_in;
		logic [SW-1:0]   side_in;
		logic            vld_in;
		logic [DIVW:0]   part;
		logic [DIVW:0]   diff;

		if (k == 0) begin : g_first
			assign rem_in  = rem_init;
			assign quo_in  = dividend[QW-1:0];
			assign side_in = in_side;
			assign vld_in  = in_valid;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign quo_in  = quo_s[k-1];
			assign side_in = side_s[k-1];
			assign vld_in  = vld_s[k-1];
		end

		assign part = {rem_in, quo_in[QW-1]};
		assign diff = part - {1'b0, divisor};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= diff[DIVW] ? part[DIVW-1:0] : diff[DIVW-1:0];
				quo_s[k]  <= {quo_in[QW-2:0], ~diff[DIVW]};
				side_s[k] <= side_in;
			end
		end
	end

	assign out_valid = vld_s[QW-1];
	assign quotient  = quo_s[QW-1];
	assign remainder = rem_s[QW-1];
	assign out_side  = side_s[QW-1];

endmodule

>>> rtl/core/bcm_lvl_div.sv
`timescale 1ns / 1ps
// bcm_lvl_div: iterative divider for the segment count of the mapped range
// one quotient bit per cycle after a register write; uses bcm_pkg
module bcm_lvl_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [31:0]       min_level,
	input  logic signed [31:0]       max_level,
	input  logic [30:0]              width,
	output logic                     busy,
	output bcm_pkg::lvl_info_t       info
);

	import bcm_pkg::*;

	localparam int STEPS = 33;
	localparam int CW    = $clog2(STEPS);

	logic [32:0]   diff;
	logic [33:0]   up;
	logic [32:0]   num;
	logic [31:0]   part;
	logic [31:0]   trial;
	logic [30:0]   rem_nx;
	logic [32:0]   quo_nx;

	logic [30:0]   rem_q;
	logic [32:0]   quo_q;
	logic [CW-1:0] step_q;
	logic          neg_q;
	logic          busy_q;
	lvl_info_t     info_q;

	always_comb begin
		diff   = {max_level[31], max_level} - {min_level[31], min_level};
		// ceiling for a rising range, plain floor of the magnitude otherwise
		up     = {1'b0, diff} + {3'b0, width} - 34'd1;
		num    = diff[32] ? (33'd0 - diff) : up[32:0];
		part   = {rem_q, quo_q[32]};
		trial  = part - {1'b0, width};
		rem_nx = trial[31] ? part[30:0] : trial[30:0];
		quo_nx = {quo_q[31:0], ~trial[31]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= '0;
			info_q.mode <= LVL_DIV;
			info_q.segs <= RST_LVL_SEGS;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + CW'(1);
			if (step_q == CW'(STEPS-1)) begin
				busy_q      <= 1'b0;
				info_q.segs <= quo_nx[31:0];
				if (quo_nx == '0) begin
					info_q.mode <= LVL_ZERO;
				end else if (neg_q) begin
					info_q.mode <= LVL_NEG;
				end else begin
					info_q.mode <= LVL_DIV;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			neg_q <= diff[32];
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= quo_nx;
		end
	end

	assign busy = busy_q;
	assign info = info_q;

endmodule

>>> rtl/core/banded_rainbow_colormap.sv
`timescale 1ns / 1ps
// banded_rainbow_colormap: Q16.16 sample to banded rainbow RGBA, top level
// depends on bcm_pkg, bcm_div_pipe and bcm_lvl_div
//
//   port group     dir   handshake              content
//   cfg_*          in    cfg_write              register index, 32 bit data
//   in_*, sample   in    in_valid / in_ready    sample_value, is_not_a_number, is_infinite
//   out_*, levels  out   out_valid / out_ready  red, green, blue, alpha levels
//
// one word per cycle unless the output buffer is full or a config write is pending;
// results pass the 32 stage segment, 12 stage index and 8 stage channel dividers
// after a register write in_ready stays low while the segment count of the range
// is recomputed one bit per cycle
// a two word output buffer takes results while out_ready is low; the pipeline
// freezes only once both words are held, so nothing is dropped or repeated
module banded_rainbow_colormap (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  bcm_pkg::cfg_reg_t    cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [31:0]   sample_value,
	input  logic                 is_not_a_number,
	input  logic                 is_infinite,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           red_level,
	output logic [7:0]           green_level,
	output logic [7:0]           blue_level,
	output logic [7:0]           alpha_level
);

	import bcm_pkg::*;

	// configuration
	logic signed [31:0]  min_level_q;
	logic signed [31:0]  max_level_q;
	logic [WIDTH_W-1:0]  width_q;
	logic [CNT_W-1:0]    count_q;
	logic [7:0]          stripe_q;
	logic                start_q;
	logic [WIDTH_W-1:0]  w_eff;
	logic [CNT_W-1:0]    n_eff;
	logic                lvl_busy;
	lvl_info_t           lvl;

	// flow control
	logic                en;
	logic                accept;

	// stage 1
	logic                v_s1;
	logic [31:0]         uv_s1;
	special_t            spc_s1;
	logic [32:0]         diff_in;

	// segment divider
	logic                seg_v;
	logic [31:0]         seg;
	logic [30:0]         seg_rem;
	logic [1:0]          seg_side;

	// stage 2
	logic                v_s2;
	logic [44:0]         p_s2;
	logic [39:0]         sprod_s2;
	idx_sel_t            sel_s2;
	special_t            spc_s2;
	idx_sel_t            sel_d;
	logic [31:0]         r2;

	// index and stripe dividers
	logic                idx_v;
	logic [IDX_W-1:0]    idx_quo;
	logic [1:0]          idx_side;
	logic                str_v;
	logic [31:0]         str_rem;
	logic [1:0]          str_side;

	// stages 3 to 5
	logic                v_s3;
	logic [IDX_W-1:0]    idx_s3;
	logic                dark_s3;
	special_t            spc_s3;
	logic                v_s4;
	logic [14:0]         rn_s4;
	logic [14:0]         gn_s4;
	logic [14:0]         bn_s4;
	logic                dark_s4;
	special_t            spc_s4;
	logic                v_s5;
	logic [25:0]         rx_s5;
	logic [25:0]         gx_s5;
	logic [25:0]         bx_s5;
	special_t            spc_s5;
	logic [16:0]         i4;
	logic [16:0]         n1;
	logic [16:0]         den;
	logic [16:0]         rn_d;
	logic [16:0]         gn_d;
	logic [16:0]         bn_d;
	logic [10:0]         gain;

	// channel dividers
	logic                red_v;
	logic                grn_v;
	logic                blu_v;
	logic [7:0]          red_q;
	logic [7:0]          grn_q;
	logic [7:0]          blu_q;
	logic [1:0]          red_side;
	logic [1:0]          grn_side;
	logic [1:0]          blu_side;

	// output buffer
	rgba_t               rgba_d;
	rgba_t               ent0_q;
	rgba_t               ent1_q;
	logic [1:0]          cnt_q;
	logic                push;
	logic                pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_level_q <= RST_MIN_LEVEL;
			max_level_q <= RST_MAX_LEVEL;
			width_q     <= RST_SEGMENT_WIDTH;
			count_q     <= RST_COLOR_COUNT;
			stripe_q    <= RST_STRIPE_DIVISIONS;
			start_q     <= 1'b0;
		end else begin
			start_q <= cfg_write;
			if (cfg_write) begin
				unique case (cfg_index)
					REG_MIN_LEVEL:        min_level_q <= cfg_data;
					REG_MAX_LEVEL:        max_level_q <= cfg_data;
					REG_SEGMENT_WIDTH:    width_q     <= cfg_data[WIDTH_W-1:0];
					REG_COLOR_COUNT:      count_q     <= cfg_data[CNT_W-1:0];
					REG_STRIPE_DIVISIONS: stripe_q    <= cfg_data[7:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		w_eff = (width_q == '0) ? WIDTH_W'(1) : width_q;
		if (count_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (count_q > CNT_W'(MAX_COLORS)) begin
			n_eff = CNT_W'(MAX_COLORS);
		end else begin
			n_eff = count_q;
		end
	end

	bcm_lvl_div u_lvl_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start_q),
		.min_level (min_level_q),
		.max_level (max_level_q),
		.width     (w_eff),
		.busy      (lvl_busy),
		.info      (lvl)
	);

	assign en       = (cnt_q != 2'd2);
	assign in_ready = en & ~lvl_busy & ~start_q & ~cfg_write;
	assign accept   = in_valid & in_ready;

	// stage 1: offset by the minimum, clamp at zero
	assign diff_in = {sample_value[31], sample_value} - {min_level_q[31], min_level_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			uv_s1 <= diff_in[32] ? 32'd0 : diff_in[31:0];
			if (is_not_a_number) begin
				spc_s1 <= SPC_NAN;
			end else if (is_infinite) begin
				spc_s1 <= SPC_INF;
			end else begin
				spc_s1 <= SPC_NONE;
			end
		end
	end

	bcm_div_pipe #(.NW(33), .QW(32), .DIVW(31), .SW(2)) u_seg_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.dividend  ({1'b0, uv_s1}),
		.divisor   (w_eff),
		.in_side   (spc_s1),
		.out_valid (seg_v),
		.quotient  (seg),
		.remainder (seg_rem),
		.out_side  (seg_side)
	);

	// stage 2: index numerator and stripe phase
	always_comb begin
		unique case (lvl.mode)
			LVL_ZERO: sel_d = SEL_TOP;
			LVL_NEG:  sel_d = SEL_ZERO;
			default:  sel_d = (seg >= lvl.segs) ? SEL_TOP : SEL_DIV;
		endcase
		// value modulo twice the width, from the odd or even segment
		r2 = {1'b0, seg_rem} + (seg[0] ? {1'b0, w_eff} : 32'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= seg_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2     <= 45'(n_eff) * 45'(seg);
			sprod_s2 <= 40'(r2) * 40'(stripe_q);
			sel_s2   <= sel_d;
			spc_s2   <= special_t'(seg_side);
		end
	end

	bcm_div_pipe #(.NW(45), .QW(IDX_W), .DIVW(32), .SW(2)) u_idx_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.dividend  (p_s2),
		.divisor   (lvl.segs),
		.in_side   (sel_s2),
		.out_valid (idx_v),
		.quotient  (idx_quo),
		.remainder (),
		.out_side  (idx_side)
	);

	bcm_div_pipe #(.NW(44), .QW(IDX_W), .DIVW(32), .SW(2)) u_stripe_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.dividend  ({4'b0, sprod_s2}),
		.divisor   ({w_eff, 1'b0}),
		.in_side   (spc_s2),
		.out_valid (str_v),
		.quotient  (),
		.remainder (str_rem),
		.out_side  (str_side)
	);

	// stage 3: colour index and stripe darkening
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= idx_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			unique case (idx_sel_t'(idx_side))
				SEL_TOP:  idx_s3 <= IDX_W'(n_eff - CNT_W'(1));
				SEL_ZERO: idx_s3 <= '0;
				default:  idx_s3 <= idx_quo;
			endcase
			dark_s3 <= (str_rem > {1'b0, w_eff});
			spc_s3  <= special_t'(str_side);
		end
	end

	// stage 4: palette numerators over 4n
	always_comb begin
		i4  = 17'(idx_s3) << 2;
		n1  = 17'(n_eff);
		den = n1 << 2;
		priority if (i4 < n1) begin
			rn_d = '0;
			gn_d = i4 << 2;
			bn_d = den;
		end else if (i4 < (n1 << 1)) begin
			rn_d = '0;
			gn_d = den;
			bn_d = (n1 * 17'd7) - (i4 * 17'd3);
		end else if (i4 < (n1 * 17'd3)) begin
			rn_d = (i4 * 17'd3) - (n1 * 17'd5);
			gn_d = den;
			bn_d = '0;
		end else begin
			rn_d = den;
			gn_d = (n1 - 17'(idx_s3)) << 4;
			bn_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rn_s4   <= rn_d[14:0];
			gn_s4   <= gn_d[14:0];
			bn_s4   <= bn_d[14:0];
			dark_s4 <= dark_s3;
			spc_s4  <= spc_s3;
		end
	end

	// stage 5: rounding numerators, half of the divisor added
	assign gain = dark_s4 ? CHAN_GAIN_DARK : CHAN_GAIN_FULL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s5  <= 26'(rn_s4) * 26'(gain) + (26'(n_eff) << 4);
			gx_s5  <= 26'(gn_s4) * 26'(gain) + (26'(n_eff) << 4);
			bx_s5  <= 26'(bn_s4) * 26'(gain) + (26'(n_eff) << 4);
			spc_s5 <= spc_s4;
		end
	end

	bcm_div_pipe #(.NW(26), .QW(8), .DIVW(18), .SW(2)) u_red_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s5),
		.dividend  (rx_s5),
		.divisor   ({n_eff, 5'b0}),
		.in_side   (spc_s5),
		.out_valid (red_v),
		.quotient  (red_q),
		.remainder (),
		.out_side  (red_side)
	);

	bcm_div_pipe #(.NW(26), .QW(8), .DIVW(18), .SW(2)) u_grn_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s5),
		.dividend  (gx_s5),
		.divisor   ({n_eff, 5'b0}),
		.in_side   (spc_s5),
		.out_valid (grn_v),
		.quotient  (grn_q),
		.remainder (),
		.out_side  (grn_side)
	);

	bcm_div_pipe #(.NW(26), .QW(8), .DIVW(18), .SW(2)) u_blu_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s5),
		.dividend  (bx_s5),
		.divisor   ({n_eff, 5'b0}),
		.in_side   (spc_s5),
		.out_valid (blu_v),
		.quotient  (blu_q),
		.remainder (),
		.out_side  (blu_side)
	);

	// final colour, special samples override the palette
	always_comb begin
		unique case (special_t'(red_side))
			SPC_NAN: rgba_d = '{red: 8'hff, green: 8'hff, blue: 8'hff, alpha: 8'h00};
			SPC_INF: rgba_d = '{red: 8'h00, green: 8'h00, blue: 8'h00, alpha: 8'h00};
			default: rgba_d = '{red: red_q, green: grn_q, blue: blu_q, alpha: 8'hff};
		endcase
	end

	// two word output buffer
	assign push      = red_v & en;
	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid & out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent0_q <= (cnt_q == 2'd2) ? ent1_q : rgba_d;
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				ent0_q <= rgba_d;
			end else begin
				ent1_q <= rgba_d;
			end
		end
	end

	assign red_level   = ent0_q.red;
	assign green_level = ent0_q.green;
	assign blue_level  = ent0_q.blue;
	assign alpha_level = ent0_q.alpha;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !lvl_busy)
		else $error("word accepted while range segment count is recomputed");

	a_idx_stripe_align: assert property (@(posedge clk) disable iff (!arst_n)
		idx_v == str_v)
		else $error("index and stripe dividers out of step");

	a_chan_align: assert property (@(posedge clk) disable iff (!arst_n)
		red_v |-> (grn_v && blu_v && red_side == grn_side && red_side == blu_side))
		else $error("channel dividers out of step");

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q != 2'd2))
		else $error("output buffer written while full");

endmodule
